[hdl/tlcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcm_pkg
// Shared types, widths, register indexes and reset values of the two level
// LRU cache tag model.
// ----------------------------------------------------------------------------
package tlcm_pkg;

    localparam int ADDR_W   = 64;
    localparam int LSIZE_W  = 13;
    localparam int CAP1_W   = 7;
    localparam int CAP2_W   = 11;
    localparam int LAT_W    = 16;
    localparam int TALLY_W  = 6;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;
    localparam int OUT_DW   = 40;

    localparam int DEF_FIRST_LEVEL_DEPTH  = 64;
    localparam int DEF_SECOND_LEVEL_DEPTH = 1024;
    localparam int DEF_BATCH_MAX          = 32;

    localparam logic [CFG_AW-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_LSIZE  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_CAP1   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_CAP2   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_LAT1   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_LAT2   = 3'd5;
    localparam logic [CFG_AW-1:0] REG_LATD   = 3'd6;

    localparam logic [LSIZE_W-1:0] RST_LSIZE = 13'd128;
    localparam logic [LAT_W-1:0]   RST_LAT1  = 16'd4;
    localparam logic [LAT_W-1:0]   RST_LAT2  = 16'd20;
    localparam logic [LAT_W-1:0]   RST_LATD  = 16'd200;

    localparam logic KIND_PROBE   = 1'b0;
    localparam logic KIND_PROMOTE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic              last;
        logic [ADDR_W-1:0] line;
    } t_line_item;

    typedef struct packed {
        logic              enabled;
        logic [CAP1_W-1:0] cap1;
        logic [CAP2_W-1:0] cap2;
        logic [LAT_W-1:0]  lat1;
        logic [LAT_W-1:0]  lat2;
        logic [LAT_W-1:0]  latd;
    } t_cfg;

    typedef struct packed {
        logic [TALLY_W-1:0] miss;
        logic [TALLY_W-1:0] hit2;
        logic [TALLY_W-1:0] hit1;
        logic [LAT_W-1:0]   lat;
    } t_result;

endpackage

[hdl/tlcm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcm_front
// Takes address beats and turns each into a line number with a restoring
// divider, one quotient bit per cycle; a zero line size passes the address through.
// ----------------------------------------------------------------------------
module tlcm_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_kind,
    input  logic                         i_last,
    input  logic [tlcm_pkg::ADDR_W-1:0]  i_addr,
    input  logic [tlcm_pkg::LSIZE_W-1:0] i_line_size,
    output logic                         o_valid,
    input  logic                         i_ready,
    output tlcm_pkg::t_line_item         o_item
);

    logic                         r_div;
    logic                         r_hold;
    logic                         r_kind;
    logic                         r_last;
    logic [tlcm_pkg::ADDR_W-1:0]  r_q;
    logic [tlcm_pkg::LSIZE_W-1:0] r_rem;
    logic [tlcm_pkg::LSIZE_W-1:0] r_dvs;
    logic [5:0]                   r_bit;

    logic [tlcm_pkg::LSIZE_W:0]   w_rem_sh;
    logic [tlcm_pkg::LSIZE_W:0]   w_rem_sub;
    logic                         w_ge;

    assign w_rem_sh  = {r_rem, r_q[tlcm_pkg::ADDR_W-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_dvs};
    assign w_rem_sub = w_rem_sh - {1'b0, r_dvs};

    assign o_ready = !(r_div || r_hold);
    assign o_valid = r_hold;
    assign o_item  = '{kind: r_kind, last: r_last, line: r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div  <= 1'b0;
            r_hold <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_kind <= i_kind;
                r_last <= i_last;
                r_q    <= i_addr;
                r_dvs  <= i_line_size;
                r_rem  <= '0;
                r_bit  <= 6'd63;
                if (i_line_size == '0) begin
                    r_hold <= 1'b1;
                end else begin
                    r_div <= 1'b1;
                end
            end
            if (r_div) begin
                r_q   <= {r_q[tlcm_pkg::ADDR_W-2:0], w_ge};
                r_rem <= w_ge ? w_rem_sub[tlcm_pkg::LSIZE_W-1:0]
                              : w_rem_sh[tlcm_pkg::LSIZE_W-1:0];
                r_bit <= r_bit - 6'd1;
                if (r_bit == 6'd0) begin
                    r_div  <= 1'b0;
                    r_hold <= 1'b1;
                end
            end
            if (r_hold && i_ready) begin
                r_hold <= 1'b0;
            end
        end
    end

endmodule

[hdl/tlcm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcm_queue
// Two entry queue of line items between the front and the back.
// ----------------------------------------------------------------------------
module tlcm_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tlcm_pkg::t_line_item i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tlcm_pkg::t_line_item o_item
);

    tlcm_pkg::t_line_item r_ent [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;
    logic                 w_push;
    logic                 w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_ent[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

[hdl/tlcm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcm_back
// Sequencer over the batch, first level and second level tag stores. Each
// store is kept oldest first and scanned entry by entry over a registered port.
// ----------------------------------------------------------------------------
module tlcm_back #(
    parameter int FIRST_LEVEL_DEPTH  = tlcm_pkg::DEF_FIRST_LEVEL_DEPTH,
    parameter int SECOND_LEVEL_DEPTH = tlcm_pkg::DEF_SECOND_LEVEL_DEPTH,
    parameter int BATCH_MAX          = tlcm_pkg::DEF_BATCH_MAX
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tlcm_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tlcm_pkg::t_line_item i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tlcm_pkg::t_result    o_result
);

    localparam int MAXD = (FIRST_LEVEL_DEPTH > SECOND_LEVEL_DEPTH) ?
                          ((FIRST_LEVEL_DEPTH > BATCH_MAX) ? FIRST_LEVEL_DEPTH : BATCH_MAX) :
                          ((SECOND_LEVEL_DEPTH > BATCH_MAX) ? SECOND_LEVEL_DEPTH : BATCH_MAX);
    localparam int IW  = $clog2(MAXD + 1);
    localparam int SW  = $clog2(BATCH_MAX + 1);
    localparam int C1W = $clog2(FIRST_LEVEL_DEPTH + 1);
    localparam int C2W = $clog2(SECOND_LEVEL_DEPTH + 1);
    localparam int SAW = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
    localparam int A1W = (FIRST_LEVEL_DEPTH > 1) ? $clog2(FIRST_LEVEL_DEPTH) : 1;
    localparam int A2W = (SECOND_LEVEL_DEPTH > 1) ? $clog2(SECOND_LEVEL_DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_COMP = 3'd3;
    localparam logic [2:0] S_APP  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [1:0] SEL_SEEN = 2'd0;
    localparam logic [1:0] SEL_L1   = 2'd1;
    localparam logic [1:0] SEL_L2   = 2'd2;

    logic [tlcm_pkg::ADDR_W-1:0] r_seen_mem [BATCH_MAX];
    logic [tlcm_pkg::ADDR_W-1:0] r_l1_mem   [FIRST_LEVEL_DEPTH];
    logic [tlcm_pkg::ADDR_W-1:0] r_l2_mem   [SECOND_LEVEL_DEPTH];
    logic [tlcm_pkg::ADDR_W-1:0] r_seen_rd;
    logic [tlcm_pkg::ADDR_W-1:0] r_l1_rd;
    logic [tlcm_pkg::ADDR_W-1:0] r_l2_rd;

    logic [2:0]                  r_state;
    logic [1:0]                  r_sel;
    logic                        r_ph;
    logic                        r_found;
    logic                        r_drop;
    logic [IW-1:0]               r_idx;
    logic [IW-1:0]               r_pos;
    logic [IW-1:0]               r_w;
    logic                        r_kind;
    logic                        r_last;
    logic [tlcm_pkg::ADDR_W-1:0] r_line;
    logic [SW-1:0]               r_seen_cnt;
    logic [C1W-1:0]              r_cnt1;
    logic [C2W-1:0]              r_cnt2;
    logic [tlcm_pkg::LAT_W-1:0]  r_lat;
    logic [tlcm_pkg::TALLY_W-1:0] r_t1;
    logic [tlcm_pkg::TALLY_W-1:0] r_t2;
    logic [tlcm_pkg::TALLY_W-1:0] r_tm;
    logic                        r_ovalid;
    tlcm_pkg::t_result           r_res;

    logic [IW-1:0]               w_cnt;
    logic [tlcm_pkg::ADDR_W-1:0] w_rd;
    logic [IW-1:0]               w_cap;
    logic [IW-1:0]               w_cnt_rem;
    logic                        w_evict;
    logic                        w_keep;
    logic                        w_wr_store;
    logic [tlcm_pkg::ADDR_W-1:0] w_wdata;
    logic                        w_seen_we;
    logic [tlcm_pkg::LAT_W-1:0]  w_lat_hit;
    logic                        w_res_load;

    always_comb begin
        unique case (r_sel)
            SEL_L1: begin
                w_cnt = IW'(r_cnt1);
                w_rd  = r_l1_rd;
                w_cap = (i_cfg.cap1 == '0 || 32'(i_cfg.cap1) > FIRST_LEVEL_DEPTH) ?
                        IW'(FIRST_LEVEL_DEPTH) : IW'(i_cfg.cap1);
            end
            SEL_L2: begin
                w_cnt = IW'(r_cnt2);
                w_rd  = r_l2_rd;
                w_cap = (i_cfg.cap2 == '0 || 32'(i_cfg.cap2) > SECOND_LEVEL_DEPTH) ?
                        IW'(SECOND_LEVEL_DEPTH) : IW'(i_cfg.cap2);
            end
            default: begin
                w_cnt = IW'(r_seen_cnt);
                w_rd  = r_seen_rd;
                w_cap = IW'(BATCH_MAX);
            end
        endcase
    end

    assign w_cnt_rem  = w_cnt - IW'(r_found);
    assign w_evict    = (w_cnt_rem >= w_cap) && (w_cnt_rem != '0);
    assign w_keep     = !(r_found && r_idx == r_pos) && !r_drop;
    assign w_wr_store = (r_state == S_COMP && r_ph && w_keep) || (r_state == S_APP);
    assign w_wdata    = (r_state == S_APP) ? r_line : w_rd;
    assign w_seen_we  = r_state == S_DEC && r_sel == SEL_SEEN && !r_found &&
                        r_seen_cnt < SW'(BATCH_MAX);
    assign w_res_load = r_state == S_FIN && r_last && r_kind == tlcm_pkg::KIND_PROBE &&
                        (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        r_seen_rd <= r_seen_mem[r_idx[SAW-1:0]];
        if (w_seen_we) begin
            r_seen_mem[r_seen_cnt[SAW-1:0]] <= r_line;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l1_rd <= r_l1_mem[r_idx[A1W-1:0]];
        if (w_wr_store && r_sel == SEL_L1) begin
            r_l1_mem[r_w[A1W-1:0]] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l2_rd <= r_l2_mem[r_idx[A2W-1:0]];
        if (w_wr_store && r_sel == SEL_L2) begin
            r_l2_mem[r_w[A2W-1:0]] <= w_wdata;
        end
    end

    assign w_lat_hit = (r_sel == SEL_L1) ? i_cfg.lat1 : i_cfg.lat2;

    assign o_ready  = r_state == S_IDLE;
    assign o_valid  = r_ovalid;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sel      <= SEL_SEEN;
            r_ph       <= 1'b0;
            r_seen_cnt <= '0;
            r_cnt1     <= '0;
            r_cnt2     <= '0;
            r_lat      <= '0;
            r_t1       <= '0;
            r_t2       <= '0;
            r_tm       <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && !w_res_load) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_item.kind;
                        r_last  <= i_item.last;
                        r_line  <= i_item.line;
                        r_sel   <= SEL_SEEN;
                        r_idx   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (!r_ph) begin
                        if (r_idx == w_cnt) begin
                            r_found <= 1'b0;
                            r_state <= S_DEC;
                        end else begin
                            r_ph <= 1'b1;
                        end
                    end else if (w_rd == r_line) begin
                        r_found <= 1'b1;
                        r_pos   <= r_idx;
                        r_state <= S_DEC;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                        r_ph  <= 1'b0;
                    end
                end
                S_DEC: begin
                    r_idx <= '0;
                    r_ph  <= 1'b0;
                    if (r_sel == SEL_SEEN) begin
                        if (r_found || !w_seen_we) begin
                            r_state <= S_FIN;
                        end else begin
                            r_seen_cnt <= r_seen_cnt + SW'(1);
                            if (r_kind == tlcm_pkg::KIND_PROBE) begin
                                if (!i_cfg.enabled) begin
                                    r_tm    <= r_tm + tlcm_pkg::TALLY_W'(1);
                                    if (i_cfg.latd > r_lat) r_lat <= i_cfg.latd;
                                    r_state <= S_FIN;
                                end else begin
                                    r_sel   <= SEL_L1;
                                    r_state <= S_FIND;
                                end
                            end else if (i_cfg.enabled) begin
                                r_sel   <= SEL_L2;
                                r_state <= S_FIND;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                    end else if (r_kind == tlcm_pkg::KIND_PROBE) begin
                        if (r_found) begin
                            if (r_sel == SEL_L1) r_t1 <= r_t1 + tlcm_pkg::TALLY_W'(1);
                            else                 r_t2 <= r_t2 + tlcm_pkg::TALLY_W'(1);
                            if (w_lat_hit > r_lat) r_lat <= w_lat_hit;
                            r_state <= S_FIN;
                        end else if (r_sel == SEL_L1) begin
                            r_sel   <= SEL_L2;
                            r_state <= S_FIND;
                        end else begin
                            r_tm    <= r_tm + tlcm_pkg::TALLY_W'(1);
                            if (i_cfg.latd > r_lat) r_lat <= i_cfg.latd;
                            r_state <= S_FIN;
                        end
                    end else if (!r_found && !w_evict) begin
                        r_w     <= w_cnt;
                        r_state <= S_APP;
                    end else begin
                        r_w     <= '0;
                        r_drop  <= w_evict;
                        r_state <= S_COMP;
                    end
                end
                S_COMP: begin
                    if (!r_ph) begin
                        if (r_idx == w_cnt) begin
                            r_state <= S_APP;
                        end else begin
                            r_ph <= 1'b1;
                        end
                    end else begin
                        if (w_keep) begin
                            r_w <= r_w + IW'(1);
                        end else if (!(r_found && r_idx == r_pos)) begin
                            r_drop <= 1'b0;
                        end
                        r_idx <= r_idx + IW'(1);
                        r_ph  <= 1'b0;
                    end
                end
                S_APP: begin
                    r_idx <= '0;
                    r_ph  <= 1'b0;
                    if (r_sel == SEL_L2) begin
                        r_cnt2  <= C2W'(r_w + IW'(1));
                        r_sel   <= SEL_L1;
                        r_state <= S_FIND;
                    end else begin
                        r_cnt1  <= C1W'(r_w + IW'(1));
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_kind == tlcm_pkg::KIND_PROMOTE ||
                                 !r_ovalid || i_ready) begin
                        if (r_kind == tlcm_pkg::KIND_PROBE) begin
                            r_ovalid <= 1'b1;
                            r_res    <= '{miss: r_tm, hit2: r_t2, hit1: r_t1, lat: r_lat};
                        end
                        r_seen_cnt <= '0;
                        r_lat      <= '0;
                        r_t1       <= '0;
                        r_t2       <= '0;
                        r_tm       <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/two_level_lru_cache_tag_model.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_lru_cache_tag_model
// Tag-only model of two fully associative LRU cache levels fed by address
// beats grouped into probe and promote batches.
// ----------------------------------------------------------------------------
// Each address beat first goes through the line divider, one quotient bit per
// cycle when a line size is set; a zero line size passes the address through.
// The line then waits in a two entry queue for the tag sequencer, which reads
// its stores through one registered port each: every beat scans the batch
// store, a probe adds a scan of the first level and, on a miss, of the second,
// and a promote adds a scan and possibly a compaction pass of each level. The
// front and the sequencer overlap: the front can divide the next beat while
// the sequencer works on the last. No clearing pass after reset.
// ----------------------------------------------------------------------------
module two_level_lru_cache_tag_model #(
    parameter int FIRST_LEVEL_DEPTH  = tlcm_pkg::DEF_FIRST_LEVEL_DEPTH,
    parameter int SECOND_LEVEL_DEPTH = tlcm_pkg::DEF_SECOND_LEVEL_DEPTH,
    parameter int BATCH_MAX          = tlcm_pkg::DEF_BATCH_MAX
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [tlcm_pkg::ADDR_W-1:0] s_axis_tdata,  // byte_address
    input  logic                        s_axis_tlast,  // batch_last
    input  logic                        s_axis_tuser,  // kind
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // worst_latency, first_level_hits, second_level_hits, miss_count, zero pad
    output logic [tlcm_pkg::OUT_DW-1:0] m_axis_tdata,
    input  logic                        i_cfg_we,
    input  logic [tlcm_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [tlcm_pkg::CFG_DW-1:0] i_cfg_wdata
);

    logic                         r_enabled;
    logic [tlcm_pkg::LSIZE_W-1:0] r_lsize;
    logic [tlcm_pkg::CAP1_W-1:0]  r_cap1;
    logic [tlcm_pkg::CAP2_W-1:0]  r_cap2;
    logic [tlcm_pkg::LAT_W-1:0]   r_lat1;
    logic [tlcm_pkg::LAT_W-1:0]   r_lat2;
    logic [tlcm_pkg::LAT_W-1:0]   r_latd;

    tlcm_pkg::t_cfg       w_cfg;
    tlcm_pkg::t_line_item w_f_item;
    tlcm_pkg::t_line_item w_q_item;
    tlcm_pkg::t_result    w_res;
    logic                 w_f_valid;
    logic                 w_q_ready;
    logic                 w_q_valid;
    logic                 w_b_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
            r_lsize   <= tlcm_pkg::RST_LSIZE;
            r_cap1    <= '0;
            r_cap2    <= '0;
            r_lat1    <= tlcm_pkg::RST_LAT1;
            r_lat2    <= tlcm_pkg::RST_LAT2;
            r_latd    <= tlcm_pkg::RST_LATD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tlcm_pkg::REG_ENABLE: r_enabled <= i_cfg_wdata[0];
                tlcm_pkg::REG_LSIZE:  r_lsize   <= i_cfg_wdata[tlcm_pkg::LSIZE_W-1:0];
                tlcm_pkg::REG_CAP1:   r_cap1    <= i_cfg_wdata[tlcm_pkg::CAP1_W-1:0];
                tlcm_pkg::REG_CAP2:   r_cap2    <= i_cfg_wdata[tlcm_pkg::CAP2_W-1:0];
                tlcm_pkg::REG_LAT1:   r_lat1    <= i_cfg_wdata;
                tlcm_pkg::REG_LAT2:   r_lat2    <= i_cfg_wdata;
                tlcm_pkg::REG_LATD:   r_latd    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_cfg = '{enabled: r_enabled, cap1: r_cap1, cap2: r_cap2,
                     lat1: r_lat1, lat2: r_lat2, latd: r_latd};

    tlcm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_last      (s_axis_tlast),
        .i_addr      (s_axis_tdata),
        .i_line_size (r_lsize),
        .o_valid     (w_f_valid),
        .i_ready     (w_q_ready),
        .o_item      (w_f_item)
    );

    tlcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_q_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_ready (w_b_ready),
        .o_item  (w_q_item)
    );

    tlcm_back #(
        .FIRST_LEVEL_DEPTH  (FIRST_LEVEL_DEPTH),
        .SECOND_LEVEL_DEPTH (SECOND_LEVEL_DEPTH),
        .BATCH_MAX          (BATCH_MAX)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_q_valid),
        .o_ready  (w_b_ready),
        .i_item   (w_q_item),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.miss, w_res.hit2, w_res.hit1, w_res.lat};

    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_f_valid && !w_q_ready) |=> (w_f_valid && $stable(w_f_item)))
        else $error("front beat changed while queue full");

    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_f_valid |-> !s_axis_tready)
        else $error("front accepted a beat while holding one");

    a_tally_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (8'(w_res.hit1) + 8'(w_res.hit2) + 8'(w_res.miss)
                           <= 8'(BATCH_MAX)))
        else $error("batch tallies exceed batch limit");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two level LRU cache tag model. Address beats
// are grouped into probe and promote batches, drawn mostly from a small pool
// of lines per phase so that hits, evictions and capacity limits are reached.
// Results are predicted by an LRU store model and compared per field.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic                        kind;
        logic [tlcm_pkg::ADDR_W-1:0] addr;
        logic                        last;
    } t_beat;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [tlcm_pkg::ADDR_W-1:0]   s_axis_tdata;
    logic                          s_axis_tlast;
    logic                          s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [tlcm_pkg::OUT_DW-1:0]   m_axis_tdata;
    logic                          i_cfg_we;
    logic [tlcm_pkg::CFG_AW-1:0]   i_cfg_addr;
    logic [tlcm_pkg::CFG_DW-1:0]   i_cfg_wdata;

    two_level_lru_cache_tag_model DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // cache model state
    logic                          c_en;
    logic [tlcm_pkg::LSIZE_W-1:0]  c_lsize;
    logic [tlcm_pkg::CAP1_W-1:0]   c_cap1;
    logic [tlcm_pkg::CAP2_W-1:0]   c_cap2;
    logic [tlcm_pkg::LAT_W-1:0]    c_lat1, c_lat2, c_latd;
    logic [tlcm_pkg::ADDR_W-1:0]   l1_lines[$];
    logic [tlcm_pkg::ADDR_W-1:0]   l2_lines[$];
    logic [tlcm_pkg::ADDR_W-1:0]   batch_lines[$];
    logic [tlcm_pkg::LAT_W-1:0]    run_lat;
    logic [tlcm_pkg::TALLY_W-1:0]  run_hit1, run_hit2, run_miss;

    t_beat               pending[$];
    tlcm_pkg::t_result   expected_stats[$];
    t_beat               cur_beat;
    int                  errors;
    int                  send_idle_max;
    int                  recv_idle_max;
    int                  send_gap;
    int                  recv_gap;
    int                  long_hold;
    int                  results_seen;
    logic [tlcm_pkg::ADDR_W-1:0] base_line;

    function automatic bit line_present(ref logic [tlcm_pkg::ADDR_W-1:0] st[$],
                                        input logic [tlcm_pkg::ADDR_W-1:0] ln);
        foreach (st[i]) if (st[i] == ln) return 1'b1;
        return 1'b0;
    endfunction

    task automatic lru_touch(ref logic [tlcm_pkg::ADDR_W-1:0] st[$], input int depth,
                             input int cap_reg, input logic [tlcm_pkg::ADDR_W-1:0] ln);
        int cap;
        cap = (cap_reg == 0 || cap_reg > depth) ? depth : cap_reg;
        foreach (st[i]) begin
            if (st[i] == ln) begin
                st.delete(i);
                break;
            end
        end
        if (st.size() >= cap && st.size() > 0) void'(st.pop_front());
        st = {st, ln};
    endtask

    task automatic predict_beat(input t_beat b);
        logic [tlcm_pkg::ADDR_W-1:0] ln;
        logic [tlcm_pkg::LAT_W-1:0]  lat;
        tlcm_pkg::t_result           r;
        ln = (c_lsize == 0) ? b.addr : b.addr / {51'd0, c_lsize};
        if (!line_present(batch_lines, ln) && batch_lines.size() < tlcm_pkg::DEF_BATCH_MAX)
        begin
            batch_lines = {batch_lines, ln};
            if (b.kind == tlcm_pkg::KIND_PROBE) begin
                if (!c_en) begin
                    lat = c_latd;
                    run_miss++;
                end else if (line_present(l1_lines, ln)) begin
                    lat = c_lat1;
                    run_hit1++;
                end else if (line_present(l2_lines, ln)) begin
                    lat = c_lat2;
                    run_hit2++;
                end else begin
                    lat = c_latd;
                    run_miss++;
                end
                if (lat > run_lat) run_lat = lat;
            end else if (c_en) begin
                lru_touch(l2_lines, tlcm_pkg::DEF_SECOND_LEVEL_DEPTH, int'(c_cap2), ln);
                lru_touch(l1_lines, tlcm_pkg::DEF_FIRST_LEVEL_DEPTH, int'(c_cap1), ln);
            end
        end
        if (b.last) begin
            if (b.kind == tlcm_pkg::KIND_PROBE) begin
                r.lat  = run_lat;
                r.hit1 = run_hit1;
                r.hit2 = run_hit2;
                r.miss = run_miss;
                expected_stats = {expected_stats, r};
            end
            batch_lines.delete();
            run_lat  = '0;
            run_hit1 = '0;
            run_hit2 = '0;
            run_miss = '0;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) predict_beat(cur_beat);
            if (send_gap > 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
                cur_beat      = pending.pop_front();
                s_axis_tdata  <= cur_beat.addr;
                s_axis_tlast  <= cur_beat.last;
                s_axis_tuser  <= cur_beat.kind;
                s_axis_tvalid <= 1'b1;
                send_gap      <= $urandom_range(0, send_idle_max);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        tlcm_pkg::t_result got, exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
            long_hold     <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = tlcm_pkg::t_result'(m_axis_tdata[$bits(tlcm_pkg::t_result)-1:0]);
                results_seen++;
                if (expected_stats.size() == 0) begin
                    $display("%0t unexpected beat: expected none actual %h", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_stats.pop_front();
                    if (got.lat !== exp_r.lat) begin
                        $display("%0t worst_latency: expected %0d actual %0d",
                                 $time, exp_r.lat, got.lat);
                        errors++;
                    end
                    if (got.hit1 !== exp_r.hit1) begin
                        $display("%0t first_level_hits: expected %0d actual %0d",
                                 $time, exp_r.hit1, got.hit1);
                        errors++;
                    end
                    if (got.hit2 !== exp_r.hit2) begin
                        $display("%0t second_level_hits: expected %0d actual %0d",
                                 $time, exp_r.hit2, got.hit2);
                        errors++;
                    end
                    if (got.miss !== exp_r.miss) begin
                        $display("%0t miss_count: expected %0d actual %0d",
                                 $time, exp_r.miss, got.miss);
                        errors++;
                    end
                end
                if (results_seen == 30) long_hold <= 4000;
            end
            if (long_hold > 0) begin
                long_hold     <= long_hold - 1;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap      <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready)
                    recv_gap <= $urandom_range(0, recv_idle_max);
            end
        end
    end

    task automatic push_beat(input logic kind, input logic [tlcm_pkg::ADDR_W-1:0] addr,
                             input logic last);
        t_beat b;
        b.kind = kind;
        b.addr = addr;
        b.last = last;
        pending = {pending, b};
    endtask

    function automatic logic [tlcm_pkg::ADDR_W-1:0] pool_addr(input int pool);
        logic [tlcm_pkg::ADDR_W-1:0] ln;
        ln = base_line + 64'($urandom_range(0, pool - 1));
        if (c_lsize == 0) return ln;
        return ln * {51'd0, c_lsize} + 64'($urandom_range(0, c_lsize - 1));
    endfunction

    function automatic logic [tlcm_pkg::ADDR_W-1:0] noise_addr();
        return {$urandom, $urandom};
    endfunction

    task automatic wait_idle();
        while (pending.size() > 0 || s_axis_tvalid || expected_stats.size() > 0)
            @(posedge i_clk);
        repeat (30000) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [tlcm_pkg::CFG_AW-1:0] idx,
                             input logic [tlcm_pkg::CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            tlcm_pkg::REG_ENABLE: c_en    = val[0];
            tlcm_pkg::REG_LSIZE:  c_lsize = val[tlcm_pkg::LSIZE_W-1:0];
            tlcm_pkg::REG_CAP1:   c_cap1  = val[tlcm_pkg::CAP1_W-1:0];
            tlcm_pkg::REG_CAP2:   c_cap2  = val[tlcm_pkg::CAP2_W-1:0];
            tlcm_pkg::REG_LAT1:   c_lat1  = val;
            tlcm_pkg::REG_LAT2:   c_lat2  = val;
            tlcm_pkg::REG_LATD:   c_latd  = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n_beats, input int pool);
        int sent;
        int len;
        int sel;
        logic kind;
        logic k;
        sent = 0;
        while (sent < n_beats) begin
            sel  = $urandom_range(0, 99);
            kind = 1'($urandom_range(0, 1));
            len  = (sel < 4) ? $urandom_range(33, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                k = (sel >= 4 && sel < 14) ? 1'($urandom_range(0, 1)) : kind;
                if ($urandom_range(0, 99) < ((k == tlcm_pkg::KIND_PROBE) ? 10 : 2))
                    push_beat(k, noise_addr(), i == len - 1);
                else
                    push_beat(k, pool_addr(sel < 4 ? 48 : pool), i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        logic [tlcm_pkg::CFG_DW-1:0] caps1[6] = '{16'd0, 16'd1, 16'd64, 16'd127, 16'd5,
                                                   16'd12};
        logic [tlcm_pkg::CFG_DW-1:0] caps2[6] = '{16'd0, 16'd2, 16'd2047, 16'd1024, 16'd9,
                                                   16'd20};
        logic [tlcm_pkg::CFG_DW-1:0] sizes[6] = '{16'd0, 16'd4096, 16'd1, 16'd64, 16'd4095,
                                                   16'd3};
        errors        = 0;
        results_seen  = 0;
        send_idle_max = 13;
        recv_idle_max = 13;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        c_en = 1'b1;  c_lsize = tlcm_pkg::RST_LSIZE; c_cap1 = '0; c_cap2 = '0;
        c_lat1 = tlcm_pkg::RST_LAT1; c_lat2 = tlcm_pkg::RST_LAT2; c_latd = tlcm_pkg::RST_LATD;
        run_lat = '0; run_hit1 = '0; run_hit2 = '0; run_miss = '0;
        base_line = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset configuration
        push_beat(tlcm_pkg::KIND_PROBE, 64'd0, 1'b1);
        push_beat(tlcm_pkg::KIND_PROMOTE, 64'd0, 1'b0);
        push_beat(tlcm_pkg::KIND_PROMOTE, 64'd127, 1'b0);
        push_beat(tlcm_pkg::KIND_PROMOTE, '1, 1'b0);
        push_beat(tlcm_pkg::KIND_PROMOTE, 64'd128, 1'b1);
        push_beat(tlcm_pkg::KIND_PROBE, 64'd5, 1'b0);
        push_beat(tlcm_pkg::KIND_PROBE, '1, 1'b0);
        push_beat(tlcm_pkg::KIND_PROBE, 64'd256, 1'b0);
        push_beat(tlcm_pkg::KIND_PROBE, 64'h8000_0000_0000_0000, 1'b1);
        push_beat(tlcm_pkg::KIND_PROMOTE, 64'd512, 1'b0);
        push_beat(tlcm_pkg::KIND_PROBE, 64'd513, 1'b0);
        push_beat(tlcm_pkg::KIND_PROBE, 64'd1024, 1'b1);
        push_beat(tlcm_pkg::KIND_PROBE, 64'd2048, 1'b0);
        push_beat(tlcm_pkg::KIND_PROMOTE, 64'd4096, 1'b1);
        wait_idle();
        for (int i = 0; i < 36; i++) push_beat(tlcm_pkg::KIND_PROBE, 64'(i * 128), i == 35);
        wait_idle();

        // random phases over several register settings
        for (int ph = 0; ph < 7; ph++) begin
            if (ph < 6) begin
                cfg_write(tlcm_pkg::REG_ENABLE, (ph == 4) ? 16'd0 : 16'd1);
                cfg_write(tlcm_pkg::REG_LSIZE, sizes[ph]);
                cfg_write(tlcm_pkg::REG_CAP1, caps1[ph]);
                cfg_write(tlcm_pkg::REG_CAP2, caps2[ph]);
                cfg_write(tlcm_pkg::REG_LAT1,
                          (ph == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
                cfg_write(tlcm_pkg::REG_LAT2,
                          (ph == 2) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
                cfg_write(tlcm_pkg::REG_LATD, (ph == 3) ? 16'd0 : (ph == 5) ? 16'hFFFF :
                          16'($urandom_range(0, 65535)));
            end else begin
                cfg_write(tlcm_pkg::REG_ENABLE, 16'd1);
                cfg_write(tlcm_pkg::REG_CAP1, 16'd3);
            end
            base_line = {$urandom, $urandom} >> 13;
            send_idle_max = (ph == 2) ? 0 : 13;
            recv_idle_max = (ph == 3) ? 0 : 13;
            random_phase(200, (ph % 2) ? 12 : 40);
            wait_idle();
        end
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
